### hdl/qrp_pkg.sv
// Package: word types, widths and constants for the quaternion to roll/pitch pipeline.
package qrp_pkg;

  localparam int RootW = 29;  // floor sqrt of at most 2^56
  localparam int RadW  = 57;  // radicand 2^56 - p^2
  localparam int RemW  = 60;  // square root remainder and trial width
  localparam int CordW = 38;  // CORDIC vector width with growth headroom
  localparam int AngW  = 24;  // angle in 2^-20 rad
  localparam int NIter = 20;

  localparam logic signed [AngW-1:0] AngPi     = 24'sd3294199;
  localparam logic signed [16:0]     HalfPiQ13 = 17'sd12868;
  localparam logic signed [16:0]     PiQ13     = 17'sd25736;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } quat_in_t;

  typedef struct packed {
    logic signed [14:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic               pitch_clamped;
  } angles_out_t;

  // words carried alongside the square root
  typedef struct packed {
    logic signed [33:0] s;      // 2(wx+yz)
    logic signed [33:0] c;      // 2^28 - 2(x^2+y^2)
    logic signed [28:0] p;      // 2(wy-zx), valid when not clamped
    logic               p_neg;
    logic               clamp;
  } side_t;

  // per-lane result of the CORDIC
  typedef struct packed {
    logic signed [AngW-1:0] ang;
    logic                   zero;
  } lane_res_t;

  function automatic logic signed [AngW-1:0] atan_entry(input int i);
    logic signed [AngW-1:0] r;
    unique case (i)
      0:  r = 24'sd823550;
      1:  r = 24'sd486170;
      2:  r = 24'sd256879;
      3:  r = 24'sd130396;
      4:  r = 24'sd65451;
      5:  r = 24'sd32757;
      6:  r = 24'sd16383;
      7:  r = 24'sd8192;
      8:  r = 24'sd4096;
      9:  r = 24'sd2048;
      10: r = 24'sd1024;
      11: r = 24'sd512;
      12: r = 24'sd256;
      13: r = 24'sd128;
      14: r = 24'sd64;
      15: r = 24'sd32;
      16: r = 24'sd16;
      17: r = 24'sd8;
      18: r = 24'sd4;
      19: r = 24'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### hdl/qrp_front.sv
// Front end: products, the three sums, clamp test and square root radicand.
module qrp_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  qrp_pkg::quat_in_t      quat_i,
  output logic                   valid_o,
  output qrp_pkg::side_t         side_o,
  output logic [qrp_pkg::RadW-1:0] rad_o
);
  import qrp_pkg::*;

  logic signed [31:0] wx_q, yz_q, wy_q, zx_q, xx_q, yy_q;
  logic               va_q, vb_q, vc_q, vd_q;
  side_t              sb_d, sb_q, sc_q, sd_q;
  logic [27:0]        pmag_d, pmag_q;
  logic [55:0]        psq_q;
  logic [RadW-1:0]    rad_q;
  logic signed [33:0] p_full;

  always_comb begin
    p_full   = (34'(wy_q) - 34'(zx_q)) <<< 1;
    sb_d.s   = (34'(wx_q) + 34'(yz_q)) <<< 1;
    sb_d.c   = 34'sh1000_0000 - ((34'(xx_q) + 34'(yy_q)) <<< 1);
    sb_d.p   = p_full[28:0];
    sb_d.p_neg = p_full[33];
    sb_d.clamp = (p_full >= 34'sh1000_0000) || (p_full <= -34'sh1000_0000);
    if (sb_d.clamp) begin
      pmag_d = '0;
    end else if (p_full[33]) begin
      pmag_d = 28'(-p_full);
    end else begin
      pmag_d = p_full[27:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wx_q   <= quat_i.quat_w * quat_i.quat_x;
      yz_q   <= quat_i.quat_y * quat_i.quat_z;
      wy_q   <= quat_i.quat_w * quat_i.quat_y;
      zx_q   <= quat_i.quat_z * quat_i.quat_x;
      xx_q   <= quat_i.quat_x * quat_i.quat_x;
      yy_q   <= quat_i.quat_y * quat_i.quat_y;
      sb_q   <= sb_d;
      pmag_q <= pmag_d;
      sc_q   <= sb_q;
      psq_q  <= pmag_q * pmag_q;
      sd_q   <= sc_q;
      rad_q  <= (RadW'(1) << 56) - RadW'(psq_q);
    end
  end

  assign valid_o = vd_q;
  assign side_o  = sd_q;
  assign rad_o   = rad_q;

endmodule

### hdl/qrp_isqrt.sv
// Pipelined floor square root, one result bit per stage, side words carried along.
module qrp_isqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  qrp_pkg::side_t            side_i,
  input  logic [qrp_pkg::RadW-1:0]  rad_i,
  output logic                      valid_o,
  output qrp_pkg::side_t            side_o,
  output logic [qrp_pkg::RootW-1:0] root_o
);
  import qrp_pkg::*;

  logic [RemW-1:0]  rem_q  [0:RootW];
  logic [RootW-1:0] res_q  [0:RootW];
  side_t            side_q [0:RootW];
  logic [RootW:0]   v_q;

  assign rem_q[0]  = RemW'(rad_i);
  assign res_q[0]  = '0;
  assign side_q[0] = side_i;
  assign v_q[0]    = valid_i;

  for (genvar j = 0; j < RootW; j++) begin : g_stage
    localparam int K = RootW - 1 - j;
    logic [RemW-1:0]  trial;
    logic [RemW-1:0]  rem_d;
    logic [RootW-1:0] res_d;

    always_comb begin
      trial = (RemW'(res_q[j]) << (K + 1)) + (RemW'(1) << (2 * K));
      if (rem_q[j] >= trial) begin
        rem_d = rem_q[j] - trial;
        res_d = res_q[j] | (RootW'(1) << K);
      end else begin
        rem_d = rem_q[j];
        res_d = res_q[j];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j+1] <= 1'b0;
      end else if (en_i) begin
        v_q[j+1] <= v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1]  <= rem_d;
        res_q[j+1]  <= res_d;
        side_q[j+1] <= side_q[j];
      end
    end
  end

  assign valid_o = v_q[RootW];
  assign side_o  = side_q[RootW];
  assign root_o  = res_q[RootW];

endmodule

### hdl/qrp_cordic.sv
// Two-lane vectoring CORDIC: lane 0 gives the roll angle, lane 1 the pitch angle.
module qrp_cordic (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  qrp_pkg::side_t            side_i,
  input  logic [qrp_pkg::RootW-1:0] root_i,
  output logic                      valid_o,
  output qrp_pkg::lane_res_t        roll_o,
  output qrp_pkg::lane_res_t        pitch_o,
  output logic                      clamp_o,
  output logic                      p_neg_o
);
  import qrp_pkg::*;

  logic signed [CordW-1:0] x_q   [0:NIter][0:1];
  logic signed [CordW-1:0] y_q   [0:NIter][0:1];
  logic signed [AngW-1:0]  ang_q [0:NIter][0:1];
  logic                    zero_q[0:NIter][0:1];
  logic [NIter:0]          v_q;
  logic [NIter:0]          clamp_q, pneg_q;
  logic signed [CordW-1:0] x_in [0:1];
  logic signed [CordW-1:0] y_in [0:1];

  assign y_in[0] = CordW'(side_i.s);
  assign x_in[0] = CordW'(side_i.c);
  assign y_in[1] = CordW'(side_i.p);
  assign x_in[1] = $signed({{(CordW-RootW){1'b0}}, root_i});

  // front stage: fold the left half plane onto the right
  for (genvar l = 0; l < 2; l++) begin : g_pre
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[0][l] <= (x_in[l] == '0) && (y_in[l] == '0);
        if (x_in[l] < 0) begin
          x_q[0][l]   <= -x_in[l];
          y_q[0][l]   <= -y_in[l];
          ang_q[0][l] <= (y_in[l] >= 0) ? AngPi : -AngPi;
        end else begin
          x_q[0][l]   <= x_in[l];
          y_q[0][l]   <= y_in[l];
          ang_q[0][l] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NIter-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      clamp_q <= {clamp_q[NIter-1:0], side_i.clamp};
      pneg_q  <= {pneg_q[NIter-1:0], side_i.p_neg};
    end
  end

  for (genvar i = 0; i < NIter; i++) begin : g_iter
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic signed [CordW-1:0] xs, ys;
      assign xs = x_q[i][l] >>> i;
      assign ys = y_q[i][l] >>> i;
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          zero_q[i+1][l] <= zero_q[i][l];
          if (y_q[i][l] > 0) begin
            x_q[i+1][l]   <= x_q[i][l] + ys;
            y_q[i+1][l]   <= y_q[i][l] - xs;
            ang_q[i+1][l] <= ang_q[i][l] + atan_entry(i);
          end else begin
            x_q[i+1][l]   <= x_q[i][l] - ys;
            y_q[i+1][l]   <= y_q[i][l] + xs;
            ang_q[i+1][l] <= ang_q[i][l] - atan_entry(i);
          end
        end
      end
    end
  end

  assign valid_o      = v_q[NIter];
  assign roll_o.ang   = ang_q[NIter][0];
  assign roll_o.zero  = zero_q[NIter][0];
  assign pitch_o.ang  = ang_q[NIter][1];
  assign pitch_o.zero = zero_q[NIter][1];
  assign clamp_o      = clamp_q[NIter];
  assign p_neg_o      = pneg_q[NIter];

endmodule

### hdl/quaternion_to_roll_pitch.sv
// Top level: quaternion to vehicle roll and pitch, a fully pipelined datapath.
// Throughput: one word per cycle while the output word is taken; the depth
// comes mostly from the 29 square root stages and the 20 CORDIC iterations,
// each a register stage of its own.
// The whole pipeline moves as one; it holds while the output word is not taken.
// Reset (rst_ni, asynchronous, active low) clears the valid bits only.
module quaternion_to_roll_pitch (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  qrp_pkg::quat_in_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output qrp_pkg::angles_out_t out_data_o
);
  import qrp_pkg::*;

  // global advance: the output register is free or is being taken
  logic en;

  logic               f_valid;
  side_t              f_side;
  logic [RadW-1:0]    f_rad;
  logic               s_valid;
  side_t              s_side;
  logic [RootW-1:0]   s_root;
  logic               c_valid, c_clamp, c_pneg;
  lane_res_t          c_roll, c_pitch;

  logic signed [AngW-1:0] roll_rnd, pitch_rnd;
  logic signed [16:0]     sroll, spitch;
  logic                   out_valid_q;
  angles_out_t            out_d, out_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  qrp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .quat_i  (in_data_i),
    .valid_o (f_valid),
    .side_o  (f_side),
    .rad_o   (f_rad)
  );

  qrp_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .side_i  (f_side),
    .rad_i   (f_rad),
    .valid_o (s_valid),
    .side_o  (s_side),
    .root_o  (s_root)
  );

  qrp_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_valid),
    .side_i  (s_side),
    .root_i  (s_root),
    .valid_o (c_valid),
    .roll_o  (c_roll),
    .pitch_o (c_pitch),
    .clamp_o (c_clamp),
    .p_neg_o (c_pneg)
  );

  // round half up to Q3.13, then saturate
  always_comb begin
    roll_rnd  = (c_roll.ang + AngW'(64)) >>> 7;
    pitch_rnd = (c_pitch.ang + AngW'(64)) >>> 7;

    if (c_roll.zero) begin
      sroll = '0;
    end else if (roll_rnd > AngW'(PiQ13)) begin
      sroll = PiQ13;
    end else if (roll_rnd < -AngW'(PiQ13)) begin
      sroll = -PiQ13;
    end else begin
      sroll = roll_rnd[16:0];
    end

    if (c_clamp) begin
      spitch = c_pneg ? -HalfPiQ13 : HalfPiQ13;
    end else if (c_pitch.zero) begin
      spitch = '0;
    end else if (pitch_rnd > AngW'(HalfPiQ13)) begin
      spitch = HalfPiQ13;
    end else if (pitch_rnd < -AngW'(HalfPiQ13)) begin
      spitch = -HalfPiQ13;
    end else begin
      spitch = pitch_rnd[16:0];
    end

    // vehicle frame: roll is minus sensor pitch, pitch is sensor roll
    out_d.roll_angle    = 15'(-spitch);
    out_d.pitch_angle   = sroll[15:0];
    out_d.pitch_clamped = c_clamp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= c_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### hdl/qrp_checker.sv
// Port checker for quaternion_to_roll_pitch, with its bind.
module qrp_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input qrp_pkg::angles_out_t out_data_o
);
  import qrp_pkg::*;

  // an empty output stage never blocks the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed under stall");

  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.pitch_clamped |->
      (out_data_o.roll_angle == 15'sd12868) || (out_data_o.roll_angle == -15'sd12868))
    else $error("clamped pitch not at a right angle");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_data_o.pitch_angle <= 16'sd25736) && (out_data_o.pitch_angle >= -16'sd25736) &&
      (out_data_o.roll_angle <= 15'sd12868) && (out_data_o.roll_angle >= -15'sd12868))
    else $error("angle out of range");

endmodule

bind quaternion_to_roll_pitch qrp_checker u_qrp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

### bench/testbench.sv
// Testbench: quaternion to roll/pitch pipeline against an integer angle predictor.
`timescale 1ns / 1ps

module testbench;
  import qrp_pkg::*;

  localparam int PipeLatency = 55;
  localparam int WatchLimit  = 4000;
  localparam int NumRandom   = 800;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  quat_in_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  angles_out_t out_data_o;

  quaternion_to_roll_pitch uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // words waiting to be sent, and angles waiting to come out
  quat_in_t    quat_queue[$];
  angles_out_t angle_queue[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          feed_done = 1'b0;
  bit          hold_sink = 1'b0;   // long receiver stall request
  bit          hold_feed = 1'b0;   // sender pause until drained

  // floor shift right, matching arithmetic shift on signed longint
  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_unit(int i);
    longint t[20] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                      4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
    return t[i];
  endfunction

  // vectoring CORDIC, result in 2^-20 rad
  function automatic longint vector_angle(longint y, longint x);
    longint acc, xs, ys;
    acc = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      acc = (y >= 0) ? 64'sd3294199 : -64'sd3294199;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 20; i++) begin
      xs = shr_floor(x, i);
      ys = shr_floor(y, i);
      if (y > 0) begin
        x = x + ys; y = y - xs; acc += atan_unit(i);
      end else begin
        x = x - ys; y = y + xs; acc -= atan_unit(i);
      end
    end
    return acc;
  endfunction

  function automatic longint root_floor(longint unsigned t);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > t) b >>= 2;
    while (b != 0) begin
      if (t >= res + b) begin
        t -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint round_q13(longint a, longint lim);
    longint r;
    r = shr_floor(a + 64, 7);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic angles_out_t predict_angles(quat_in_t q);
    longint w, x, y, z, unity, s, c, p, sroll, spitch;
    angles_out_t res;
    w = q.quat_w; x = q.quat_x; y = q.quat_y; z = q.quat_z;
    unity = 64'sd1 << 28;
    s = 2 * (w * x + y * z);
    c = unity - 2 * (x * x + y * y);
    p = 2 * (w * y - z * x);
    sroll = round_q13(vector_angle(s, c), 25736);
    res.pitch_clamped = 1'b0;
    if (p >= unity || p <= -unity) begin
      spitch = (p > 0) ? 64'sd12868 : -64'sd12868;
      res.pitch_clamped = 1'b1;
    end else begin
      spitch = round_q13(vector_angle(p, root_floor((64'd1 << 56) - p * p)), 12868);
    end
    res.roll_angle  = 15'(-spitch);
    res.pitch_angle = 16'(sroll);
    return res;
  endfunction

  function automatic logic signed [15:0] rand_comp();
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  function automatic quat_in_t make_quat(int w, int x, int y, int z);
    quat_in_t q;
    q.quat_w = 16'(w); q.quat_x = 16'(x); q.quat_y = 16'(y); q.quat_z = 16'(z);
    return q;
  endfunction

  // near-unit quaternion with random direction
  function automatic quat_in_t unit_quat();
    real a, b, c, d, n;
    a = $itor($signed($urandom_range(2000)) - 1000);
    b = $itor($signed($urandom_range(2000)) - 1000);
    c = $itor($signed($urandom_range(2000)) - 1000);
    d = $itor($signed($urandom_range(2000)) - 1000);
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n == 0.0) return make_quat(16384, 0, 0, 0);
    return make_quat($rtoi(a / n * 16384.0), $rtoi(b / n * 16384.0),
                     $rtoi(c / n * 16384.0), $rtoi(d / n * 16384.0));
  endfunction

  initial begin
    int h;
    // directed words: identity, extremes, zero vector, gimbal lock both ways
    quat_queue.push_back(make_quat(16384, 0, 0, 0));
    quat_queue.push_back(make_quat(0, 0, 0, 0));
    quat_queue.push_back(make_quat(16384, 16384, 16384, 16384));
    quat_queue.push_back(make_quat(-16384, -16384, -16384, -16384));
    quat_queue.push_back(make_quat(16384, -16384, 16384, -16384));
    quat_queue.push_back(make_quat(11585, 0, 11585, 0));    // pitch +90
    quat_queue.push_back(make_quat(11585, 0, -11585, 0));   // pitch -90
    quat_queue.push_back(make_quat(11586, 0, 11586, 0));    // beyond one
    quat_queue.push_back(make_quat(11585, 11585, 0, 0));    // roll +90
    quat_queue.push_back(make_quat(0, 16384, 0, 0));        // roll pi
    quat_queue.push_back(make_quat(0, -16384, 0, 0));       // roll pi again, since s is zero
    quat_queue.push_back(make_quat(0, 0, 16384, 0));
    quat_queue.push_back(make_quat(0, 0, 0, 16384));
    quat_queue.push_back(make_quat(0, 11585, 11585, 0));    // S = 0, C near -1 region
    quat_queue.push_back(make_quat(-1, -1, -1, -1));
    quat_queue.push_back(make_quat(1, 1, 1, 1));
    quat_queue.push_back(make_quat(16384, 0, 0, -16384));
    quat_queue.push_back(make_quat(-16384, 16384, 0, 0));
    // full-scale components, well beyond one
    quat_queue.push_back(make_quat(-32768, 32767, -32768, 32767));
    quat_queue.push_back(make_quat(32767, 0, 32767, 0));
    quat_queue.push_back(make_quat(-32768, -32768, 32767, -32768));
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < NumRandom; i++) begin
      if (i == 200) hold_sink = 1'b1;
      if (i == 500) hold_feed = 1'b1;
      h = $urandom_range(3);
      if (h == 0)
        quat_queue.push_back(make_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp()));
      else
        quat_queue.push_back(unit_quat());
      // keep the queue short so pressure flags land mid-run
      while (quat_queue.size() > 8) @(posedge clk_i);
    end
    wait (quat_queue.size() == 0 && !in_valid_i);
    feed_done = 1'b1;
  end

  // driver: after each accepted word, idle for the drawn number of cycles
  int  feed_gap = 0;
  bit  pause_done = 1'b0;
  always @(posedge clk_i) begin
    int gap_next;
    if (rst_ni) begin
      gap_next = feed_gap;
      if (in_valid_i && in_ready_o) begin
        angle_queue.push_back(predict_angles(in_data_i));
        gap_next = ($urandom_range(3) == 0) ? 0 : $urandom_range(7);
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (hold_feed && !pause_done && angle_queue.size() != 0) begin
          in_valid_i <= 1'b0;
        end else if (gap_next > 0) begin
          gap_next = gap_next - 1;
          in_valid_i <= 1'b0;
        end else if (quat_queue.size() != 0) begin
          if (hold_feed) pause_done <= 1'b1;
          in_data_i  <= quat_queue.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      feed_gap <= gap_next;
    end
  end

  // monitor and sink
  int  sink_gap = 0;
  int  stall_count = 0;
  bit  stall_done = 1'b0;
  always @(posedge clk_i) begin
    angles_out_t exp_w;
    int          sink_draw;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (angle_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected output word %h", out_data_o);
        end else begin
          exp_w = angle_queue.pop_front();
          if (exp_w.roll_angle !== out_data_o.roll_angle
              || exp_w.pitch_angle !== out_data_o.pitch_angle
              || exp_w.pitch_clamped !== out_data_o.pitch_clamped) begin
            mismatches++;
            if (mismatches <= 10)
              $display("word mismatch: roll %0d/%0d pitch %0d/%0d clamp %0b/%0b",
                       exp_w.roll_angle, out_data_o.roll_angle,
                       exp_w.pitch_angle, out_data_o.pitch_angle,
                       exp_w.pitch_clamped, out_data_o.pitch_clamped);
          end
        end
        sink_draw = ($urandom_range(3) == 0) ? 0 : $urandom_range(7);
        sink_gap <= (sink_draw > 0) ? sink_draw - 1 : 0;
        out_ready_i <= (sink_draw == 0);
      end else if (hold_sink && !stall_done) begin
        // long stall fills the pipeline and backs up the input
        out_ready_i <= 1'b0;
        stall_count <= stall_count + 1;
        if (stall_count == 300) stall_done <= 1'b1;
      end else if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // watchdog: cycles with nothing accepted
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("quaternion_to_roll_pitch: mismatch");
      $finish;
    end
  end

  initial begin
    wait (feed_done);
    wait (angle_queue.size() == 0);
    repeat (PipeLatency + 20) @(posedge clk_i);
    if (mismatches == 0 && angle_queue.size() == 0) begin
      $display("quaternion_to_roll_pitch: match");
    end else begin
      $display("quaternion_to_roll_pitch: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/qrp_pkg.sv
hdl/qrp_front.sv
hdl/qrp_isqrt.sv
hdl/qrp_cordic.sv
hdl/quaternion_to_roll_pitch.sv
hdl/qrp_checker.sv
bench/testbench.sv
